// ----- hw/rtl/rpvg_pkg.sv -----
// Shared types and constants for the regular polygon vertex generator.
// Holds the command/status structs between controller and datapath and the CORDIC table.
// No dependencies.
package rpvg_pkg;

   localparam int COORD_W  = 24;   // Q15.8 coordinate
   localparam int RADIUS_W = 22;   // Q14.8 radius
   localparam int SIDES_W  = 7;
   localparam int VNUM_W   = 6;
   localparam int TRIG_W   = 33;   // Q1.30 cosine/sine with headroom
   localparam int ZW       = 32;   // residual angle, one turn = 2^32
   localparam int PROD_W   = RADIUS_W + 1 + TRIG_W;
   localparam int TRIG_FRAC = 30;
   localparam int OFF_W    = PROD_W - TRIG_FRAC;
   localparam int SUM_W    = COORD_W + 3;
   localparam int ATAN_N   = 24;
   localparam int ATAN_IW  = 5;

   localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = TRIG_W'(652032874);
   localparam logic signed [SUM_W-1:0]  COORD_MAX   = SUM_W'(8388607);
   localparam logic signed [SUM_W-1:0]  COORD_MIN   = -SUM_W'(8388608);

   // atan(2^-i), one turn = 2^32
   localparam logic [31:0] ATAN_TURN32 [ATAN_N] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
   };

   typedef struct packed {
      logic load_req;
      logic div_step;
      logic angle_init;
      logic cordic_load;
      logic cordic_step;
      logic mul_x;
      logic mul_y;
      logic out_load;
      logic advance;
   } dp_cmd_type;

   typedef struct packed {
      logic req_sides_zero;
      logic div_last;
      logic cordic_last;
      logic vertex_last;
      logic out_busy;
   } dp_status_type;

endpackage

// ----- hw/rtl/regular_polygon_vertex_generator.sv -----
// One request is handled at a time: a new request is taken only once the last vertex of the
//   previous request has been loaded into the output register. All vertices of a request
//   share the single CORDIC unit.
// A request with zero sides is taken and gives no vertex; the sequencer stays idle.
// Reset is synchronous, active high: clears the sequencer and the result valid flag.
module regular_polygon_vertex_generator #(
   parameter int MAX_SIDES    = 64,
   parameter int ANGLE_BITS   = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [rpvg_pkg::COORD_W-1:0]  req_center_x,
   input  logic signed [rpvg_pkg::COORD_W-1:0]  req_center_y,
   input  logic        [rpvg_pkg::RADIUS_W-1:0] req_radius,
   input  logic        [rpvg_pkg::SIDES_W-1:0]  req_sides,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [rpvg_pkg::COORD_W-1:0]  rsp_vertex_x,
   output logic signed [rpvg_pkg::COORD_W-1:0]  rsp_vertex_y,
   output logic        [rpvg_pkg::VNUM_W-1:0]   rsp_vertex_number,
   output logic                                 rsp_last_vertex
);
   import rpvg_pkg::*;

   // Command and status between the sequencer and the datapath.
   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencer: idle -> divide -> init, then per vertex:
   // load CORDIC -> iterate -> multiply x -> multiply y -> output.
   // Hold in the output state while the previous vertex still waits downstream.
   rpvg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: the vertex angle comes from one divide per request and an
   // exact quotient/remainder stepper per vertex; cosine and sine come from the
   // shared CORDIC; one multiplier scales by the radius for x then y; round,
   // add the center and saturate into the output register.
   rpvg_datapath #(
      .MAX_SIDES    (MAX_SIDES),
      .ANGLE_BITS   (ANGLE_BITS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_center_x      (req_center_x),
      .req_center_y      (req_center_y),
      .req_radius        (req_radius),
      .req_sides         (req_sides),
      .rsp_vertex_x      (rsp_vertex_x),
      .rsp_vertex_y      (rsp_vertex_y),
      .rsp_vertex_number (rsp_vertex_number),
      .rsp_last_vertex   (rsp_last_vertex),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .cmd               (cmd),
      .status            (status)
   );

endmodule

// ----- hw/rtl/rpvg_ctrl.sv -----
// Sequencer for the regular polygon vertex generator.
// Drives datapath commands from its status; depends on rpvg_pkg.
module rpvg_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rpvg_pkg::dp_status_type status,
   output rpvg_pkg::dp_cmd_type   cmd
);
   import rpvg_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_INIT = 3'd2;
   localparam logic [2:0] ST_LOAD = 3'd3;
   localparam logic [2:0] ST_ITER = 3'd4;
   localparam logic [2:0] ST_MULX = 3'd5;
   localparam logic [2:0] ST_MULY = 3'd6;
   localparam logic [2:0] ST_OUT  = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load_req = req_valid;
            if (req_valid && !status.req_sides_zero) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.angle_init = 1'b1;
            state_in       = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.cordic_load = 1'b1;
            state_in        = ST_ITER;
         end
         ST_ITER: begin
            cmd.cordic_step = 1'b1;
            if (status.cordic_last) begin
               state_in = ST_MULX;
            end
         end
         ST_MULX: begin
            cmd.mul_x = 1'b1;
            state_in  = ST_MULY;
         end
         ST_MULY: begin
            cmd.mul_y = 1'b1;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               cmd.advance  = 1'b1;
               state_in     = status.vertex_last ? ST_IDLE : ST_LOAD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !status.req_sides_zero) |=> !req_ready)
      else $error("request accepted but controller stayed idle");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.div_step, cmd.angle_init, cmd.cordic_load, cmd.cordic_step,
                cmd.mul_x, cmd.mul_y, cmd.out_load}))
      else $error("more than one datapath phase commanded");

endmodule

// ----- hw/rtl/rpvg_datapath.sv -----
// Datapath: angle divider, angle stepper, shared CORDIC, multiplier and output register.
// Depends on rpvg_pkg; sequenced by rpvg_ctrl.
module rpvg_datapath #(
   parameter int MAX_SIDES    = 64,
   parameter int ANGLE_BITS   = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic signed [rpvg_pkg::COORD_W-1:0]  req_center_x,
   input  logic signed [rpvg_pkg::COORD_W-1:0]  req_center_y,
   input  logic        [rpvg_pkg::RADIUS_W-1:0] req_radius,
   input  logic        [rpvg_pkg::SIDES_W-1:0]  req_sides,
   output logic signed [rpvg_pkg::COORD_W-1:0]  rsp_vertex_x,
   output logic signed [rpvg_pkg::COORD_W-1:0]  rsp_vertex_y,
   output logic        [rpvg_pkg::VNUM_W-1:0]   rsp_vertex_number,
   output logic                                 rsp_last_vertex,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  rpvg_pkg::dp_cmd_type                 cmd,
   output rpvg_pkg::dp_status_type              status
);
   import rpvg_pkg::*;

   localparam int CNT_W = $clog2(ANGLE_BITS > CORDIC_STEPS ? ANGLE_BITS : CORDIC_STEPS);
   localparam int PAD_W = 32 - ANGLE_BITS;

   function automatic logic signed [COORD_W-1:0] place_coord(
      input logic signed [COORD_W-1:0] center,
      input logic signed [PROD_W-1:0]  p
   );
      logic signed [PROD_W-1:0] rnd;
      logic signed [OFF_W-1:0]  off;
      logic signed [SUM_W-1:0]  sum;
      rnd = p + (PROD_W'(1) <<< (TRIG_FRAC - 1));
      off = rnd[PROD_W-1:TRIG_FRAC];
      sum = SUM_W'(center) + SUM_W'(off);
      if (sum > COORD_MAX) begin
         place_coord = COORD_W'(COORD_MAX);
      end else if (sum < COORD_MIN) begin
         place_coord = COORD_W'(COORD_MIN);
      end else begin
         place_coord = sum[COORD_W-1:0];
      end
   endfunction

   // held request
   logic signed [COORD_W-1:0]  cx_ff, cy_ff;
   logic        [RADIUS_W-1:0] rad_ff;
   logic        [SIDES_W-1:0]  n_ff;
   logic        [SIDES_W-1:0]  n_clamp;

   // shared iteration counter
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // divider: 2^(ANGLE_BITS-1) / n
   logic [SIDES_W-1:0]    rem_ff, rem_in;
   logic [ANGLE_BITS-1:0] quo_ff;
   logic [SIDES_W:0]      div_trial;
   logic                  div_ge;

   // angle stepper
   logic [ANGLE_BITS-1:0] angle_ff, angle_in;
   logic [SIDES_W-1:0]    arem_ff, arem_in;
   logic [VNUM_W-1:0]     vertex_ff, vertex_in;
   logic [SIDES_W:0]      two_r;
   logic                  step_ge;
   logic [ANGLE_BITS-1:0] step_q;
   logic [SIDES_W-1:0]    step_r;
   logic                  rem_nz;
   logic [SIDES_W:0]      adv_sum;
   logic                  adv_carry;

   // CORDIC
   logic signed [TRIG_W-1:0] x_ff, y_ff, x_in, y_in;
   logic signed [ZW-1:0]     z_ff, z_in;
   logic [1:0]               quad_ff;
   logic [31:0]              theta;
   logic signed [TRIG_W-1:0] dx, dy;
   logic signed [ZW-1:0]     atan_w;
   logic signed [TRIG_W-1:0] cos_w, sin_w;

   // multiply and output
   logic signed [PROD_W-1:0]  prod_ff, prod_w;
   logic signed [COORD_W-1:0] vx_ff;
   logic                      rsp_valid_ff, rsp_valid_in;

   assign n_clamp = (req_sides > SIDES_W'(MAX_SIDES)) ? SIDES_W'(MAX_SIDES) : req_sides;

   // restoring divide, dividend has a single one in its top bit
   assign div_trial = {rem_ff, (cnt_ff == '0)};
   assign div_ge    = div_trial >= {1'b0, n_ff};
   assign rem_in    = div_ge ? SIDES_W'(div_trial - {1'b0, n_ff}) : div_trial[SIDES_W-1:0];

   // step of one vertex: 2^ANGLE_BITS / n from the half-turn quotient
   assign two_r   = {rem_ff, 1'b0};
   assign step_ge = two_r >= {1'b0, n_ff};
   assign step_q  = {quo_ff[ANGLE_BITS-2:0], step_ge};
   assign step_r  = step_ge ? SIDES_W'(two_r - {1'b0, n_ff}) : two_r[SIDES_W-1:0];
   assign rem_nz  = (rem_ff != '0);

   assign adv_sum   = {1'b0, arem_ff} + {1'b0, step_r};
   assign adv_carry = adv_sum >= {1'b0, n_ff};

   always_comb begin
      cnt_in    = cnt_ff;
      angle_in  = angle_ff;
      arem_in   = arem_ff;
      vertex_in = vertex_ff;
      if (cmd.load_req || cmd.cordic_load) begin
         cnt_in = '0;
      end else if (cmd.div_step || cmd.cordic_step) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (cmd.angle_init) begin
         // vertex 0 sits half a step below a full turn
         angle_in  = ANGLE_BITS'(0) - quo_ff - ANGLE_BITS'(rem_nz);
         arem_in   = rem_nz ? SIDES_W'(n_ff - rem_ff) : '0;
         vertex_in = '0;
      end else if (cmd.advance) begin
         angle_in  = angle_ff + step_q + ANGLE_BITS'(adv_carry);
         arem_in   = adv_carry ? SIDES_W'(adv_sum - {1'b0, n_ff}) : adv_sum[SIDES_W-1:0];
         vertex_in = vertex_ff + VNUM_W'(1);
      end
   end

   assign theta  = {angle_ff, {PAD_W{1'b0}}};
   assign dx     = y_ff >>> cnt_ff;
   assign dy     = x_ff >>> cnt_ff;
   assign atan_w = $signed(ATAN_TURN32[ATAN_IW'(cnt_ff)]);

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      if (cmd.cordic_load) begin
         x_in = CORDIC_GAIN;
         y_in = '0;
         z_in = ZW'({2'b00, theta[29:0]});
      end else if (cmd.cordic_step) begin
         if (!z_ff[ZW-1]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - atan_w;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + atan_w;
         end
      end
   end

   // fold the quarter turn back in
   always_comb begin
      case (quad_ff)
         2'd1: begin
            cos_w = -y_ff;
            sin_w = x_ff;
         end
         2'd2: begin
            cos_w = -x_ff;
            sin_w = -y_ff;
         end
         2'd3: begin
            cos_w = y_ff;
            sin_w = -x_ff;
         end
         default: begin
            cos_w = x_ff;
            sin_w = y_ff;
         end
      endcase
   end

   assign prod_w = $signed({1'b0, rad_ff}) * (cmd.mul_x ? cos_w : sin_w);

   assign rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cx_ff  <= req_center_x;
         cy_ff  <= req_center_y;
         rad_ff <= req_radius;
         n_ff   <= n_clamp;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[ANGLE_BITS-2:0], div_ge};
      end
      cnt_ff    <= cnt_in;
      angle_ff  <= angle_in;
      arem_ff   <= arem_in;
      vertex_ff <= vertex_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      z_ff      <= z_in;
      if (cmd.cordic_load) begin
         quad_ff <= angle_ff[ANGLE_BITS-1 -: 2];
      end
      if (cmd.mul_x || cmd.mul_y) begin
         prod_ff <= prod_w;
      end
      if (cmd.mul_y) begin
         vx_ff <= place_coord(cx_ff, prod_ff);
      end
      if (cmd.out_load) begin
         rsp_vertex_x      <= vx_ff;
         rsp_vertex_y      <= place_coord(cy_ff, prod_ff);
         rsp_vertex_number <= vertex_ff;
         rsp_last_vertex   <= status.vertex_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   assign status.req_sides_zero = (req_sides == '0);
   assign status.div_last       = (cnt_ff == CNT_W'(ANGLE_BITS - 1));
   assign status.cordic_last    = (cnt_ff == CNT_W'(CORDIC_STEPS - 1));
   assign status.vertex_last    = ((SIDES_W'(vertex_ff) + SIDES_W'(1)) == n_ff);
   assign status.out_busy       = rsp_valid_ff && !rsp_ready;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && !rsp_ready))
      else $error("output register overwritten while a result waits");

   a_remainder_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.advance |=> (arem_ff < n_ff))
      else $error("angle remainder out of range after advance");

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the regular polygon vertex generator.
// Predicts every vertex with a CORDIC model of its own and compares each result in order.
// Depends on rpvg_pkg and the regular_polygon_vertex_generator RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rpvg_pkg::*;

   // Block configuration, kept at the RTL defaults.
   localparam int MAX_SIDES    = 64;
   localparam int ANGLE_BITS   = 16;
   localparam int CORDIC_STEPS = 16;

   // Longest correct gap without any handshake is the wait for the first vertex of a
   // request plus a short stall, so this limit is far beyond it.
   localparam int WATCHDOG_LIMIT = 2000;
   // Extra time to watch for stray results once every expected vertex has arrived.
   localparam int DRAIN_CYCLES   = 200;
   // Chance, in percent, that either side idles in a given cycle.
   localparam int IDLE_PERCENT   = 21;

   typedef struct packed {
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic [RADIUS_W-1:0]       radius;
      logic [SIDES_W-1:0]        sides;
   } polygon_request_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [VNUM_W-1:0]         number;
      logic                      last;
   } vertex_type;

   // Drive every input to a known value from time zero.
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [COORD_W-1:0]  req_center_x = '0;
   logic signed [COORD_W-1:0]  req_center_y = '0;
   logic [RADIUS_W-1:0]        req_radius = '0;
   logic [SIDES_W-1:0]         req_sides = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [COORD_W-1:0]  rsp_vertex_x;
   logic signed [COORD_W-1:0]  rsp_vertex_y;
   logic [VNUM_W-1:0]          rsp_vertex_number;
   logic                       rsp_last_vertex;

   vertex_type expected_vertices[$];
   int         mismatch_count = 0;
   int         stall_cycles = 0;
   bit         idle_enabled = 1'b1;

   regular_polygon_vertex_generator #(
      .MAX_SIDES    (MAX_SIDES),
      .ANGLE_BITS   (ANGLE_BITS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_center_x      (req_center_x),
      .req_center_y      (req_center_y),
      .req_radius        (req_radius),
      .req_sides         (req_sides),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_vertex_x      (rsp_vertex_x),
      .rsp_vertex_y      (rsp_vertex_y),
      .rsp_vertex_number (rsp_vertex_number),
      .rsp_last_vertex   (rsp_last_vertex)
   );

   // 20 ns clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Vertex prediction
   // ------------------------------------------------------------------

   // Rotation-mode CORDIC: cosine and sine in Q1.30 for an angle where one
   // turn is 2^32. The top two bits pick the quadrant; the remaining quarter
   // turn is rotated from the fixed start vector (gain inverse, 0).
   function automatic void cordic_sin_cos(input logic [31:0] theta,
                                          output longint cos_q30,
                                          output longint sin_q30);
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      longint t;
      x = longint'(CORDIC_GAIN);
      y = 0;
      z = longint'(theta[29:0]);
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         // Arithmetic shifts floor toward minus infinity, as the datapath does.
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= longint'(ATAN_TURN32[i]);
         end else begin
            x += dx;
            y -= dy;
            z += longint'(ATAN_TURN32[i]);
         end
      end
      // Fold the quadrant back in by swapping and negating.
      case (theta[31:30])
         2'd1: begin
            t = x;
            x = -y;
            y = t;
         end
         2'd2: begin
            x = -x;
            y = -y;
         end
         2'd3: begin
            t = x;
            x = y;
            y = -t;
         end
         default: ;
      endcase
      cos_q30 = x;
      sin_q30 = y;
   endfunction

   // Center plus rounded radius*trig, saturated to the Q15.8 range.
   function automatic logic signed [COORD_W-1:0] place_coordinate(
         input logic signed [COORD_W-1:0] center,
         input logic [RADIUS_W-1:0]       radius,
         input longint                    trig);
      longint offset;
      longint sum;
      offset = (longint'(radius) * trig + (longint'(1) << (TRIG_FRAC - 1))) >>> TRIG_FRAC;
      sum = longint'(center) + offset;
      if (sum > longint'(COORD_MAX))
         return COORD_W'(longint'(COORD_MAX));
      if (sum < longint'(COORD_MIN))
         return COORD_W'(longint'(COORD_MIN));
      return COORD_W'(sum);
   endfunction

   // Queue up every vertex that one accepted request should produce.
   function automatic void predict_polygon(input polygon_request_type rq);
      int unsigned         n;
      longint unsigned     numer;
      logic [ANGLE_BITS-1:0] ang;
      logic [31:0]         theta;
      longint              cos_q30;
      longint              sin_q30;
      vertex_type          v;
      n = rq.sides;
      // Clamp oversized side counts; zero sides produce nothing.
      if (n > MAX_SIDES)
         n = MAX_SIDES;
      for (int unsigned k = 0; k < n; k++) begin
         // Vertex k sits at (k - 1/2) of a turn divided by n, wrapped to one turn.
         numer = longint'(2 * k + 2 * n - 1) << (ANGLE_BITS - 1);
         ang   = ANGLE_BITS'(numer / n);
         theta = 32'(ang) << (32 - ANGLE_BITS);
         cordic_sin_cos(theta, cos_q30, sin_q30);
         v.x      = place_coordinate(rq.center_x, rq.radius, cos_q30);
         v.y      = place_coordinate(rq.center_y, rq.radius, sin_q30);
         v.number = VNUM_W'(k);
         v.last   = (k + 1 == n);
         expected_vertices = {expected_vertices, v};
      end
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // Pop the oldest expected vertex for every accepted result and compare fields.
   always @(posedge clock) begin : check_vertices
      vertex_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_vertices.size() == 0) begin
            report_mismatch($sformatf("unexpected vertex %0d (%0d, %0d)",
                                      rsp_vertex_number, rsp_vertex_x, rsp_vertex_y));
         end else begin
            want = expected_vertices.pop_front();
            if (rsp_vertex_x !== want.x)
               report_mismatch($sformatf("vertex %0d x: got %0d, want %0d",
                                         want.number, rsp_vertex_x, want.x));
            if (rsp_vertex_y !== want.y)
               report_mismatch($sformatf("vertex %0d y: got %0d, want %0d",
                                         want.number, rsp_vertex_y, want.y));
            if (rsp_vertex_number !== want.number)
               report_mismatch($sformatf("vertex number: got %0d, want %0d",
                                         rsp_vertex_number, want.number));
            if (rsp_last_vertex !== want.last)
               report_mismatch($sformatf("vertex %0d last flag: got %b, want %b",
                                         want.number, rsp_last_vertex, want.last));
         end
      end
   end

   // Abort if neither channel completes a handshake for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Receiver: drop ready at random unless the no-idle stretch is running.
   always @(negedge clock) begin
      if (idle_enabled)
         rsp_ready <= ($urandom_range(99) >= IDLE_PERCENT);
      else
         rsp_ready <= 1'b1;
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   function automatic polygon_request_type make_request(input int cx, input int cy,
                                                        input int r, input int s);
      polygon_request_type rq;
      rq.center_x = COORD_W'(cx);
      rq.center_y = COORD_W'(cy);
      rq.radius   = RADIUS_W'(r);
      rq.sides    = SIDES_W'(s);
      return rq;
   endfunction

   // Random request: mostly small polygons to keep the run short, some large
   // ones, and a few with zero or oversized side counts.
   function automatic polygon_request_type random_request();
      polygon_request_type rq;
      int pick;
      pick = $urandom_range(99);
      if (pick < 70)
         rq.sides = SIDES_W'($urandom_range(1, 12));
      else if (pick < 92)
         rq.sides = SIDES_W'($urandom_range(13, MAX_SIDES));
      else if ($urandom_range(1) == 0)
         rq.sides = '0;
      else
         rq.sides = SIDES_W'($urandom_range(MAX_SIDES + 1, 127));
      case ($urandom_range(3))
         0: rq.radius = RADIUS_W'($urandom);
         1: rq.radius = RADIUS_W'($urandom_range(0, 4095));
         2: rq.radius = RADIUS_W'(4194303 - $urandom_range(0, 15));
         default: rq.radius = RADIUS_W'($urandom_range(4096, 262143));
      endcase
      // Push centers toward the rails now and then to exercise saturation.
      if ($urandom_range(3) == 0) begin
         rq.center_x = $urandom_range(1) ? COORD_W'(8388607 - $urandom_range(0, 65535))
                                         : COORD_W'(-8388608 + $urandom_range(0, 65535));
         rq.center_y = $urandom_range(1) ? COORD_W'(8388607 - $urandom_range(0, 65535))
                                         : COORD_W'(-8388608 + $urandom_range(0, 65535));
      end else begin
         rq.center_x = COORD_W'($urandom);
         rq.center_y = COORD_W'($urandom);
      end
      return rq;
   endfunction

   // Send one request. Starts and ends on a falling edge; valid stays high with
   // a steady payload until the request is taken, then the prediction is queued.
   task automatic send_request(input polygon_request_type rq);
      while (idle_enabled && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_center_x <= rq.center_x;
      req_center_y <= rq.center_y;
      req_radius   <= rq.radius;
      req_sides    <= rq.sides;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predict_polygon(rq);
      @(negedge clock);
   endtask

   // Degenerate and small shapes, including one and two sides.
   task automatic test_basic_shapes();
      send_request(make_request(0, 0, 100 * 256, 1));
      send_request(make_request(1000, -2000, 100 * 256, 2));
      send_request(make_request(-5000, 7000, 50 * 256, 3));
      send_request(make_request(0, 0, 1, 4));
      send_request(make_request(123456, -654321, 333 * 256 + 17, 6));
   endtask

   // Zero sides, the maximum, and counts above the maximum that must clamp.
   task automatic test_side_count_limits();
      send_request(make_request(10, 20, 1000, 0));
      send_request(make_request(0, 0, 4194303, MAX_SIDES));
      send_request(make_request(-256, 256, 12345, MAX_SIDES + 1));
      send_request(make_request(3000, 3000, 777, 127));
      send_request(make_request(-1, -1, 4194303, 0));
      send_request(make_request(0, 0, 2000 * 256, 8));
   endtask

   // Field extremes: full-scale radius at the rails saturates, zero radius does not.
   task automatic test_coordinate_extremes();
      send_request(make_request(8388607, 8388607, 4194303, 4));
      send_request(make_request(-8388608, -8388608, 4194303, 5));
      send_request(make_request(8388607, -8388608, 0, 3));
      send_request(make_request(-8388608, 8388607, 0, 7));
      send_request(make_request(0, 0, 4194303, 16));
      send_request(make_request(8388607, -8388608, 4194303, 12));
   endtask

   // A long stretch with no idling on either side.
   task automatic test_back_to_back();
      idle_enabled = 1'b0;
      repeat (60)
         send_request(random_request());
      idle_enabled = 1'b1;
   endtask

   // Random polygons with random idling on both sides.
   task automatic test_random_polygons();
      repeat (333)
         send_request(random_request());
   endtask

   initial begin
      // Hold reset from time zero, then release it on a falling edge.
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_basic_shapes();
      test_side_count_limits();
      test_coordinate_extremes();
      test_back_to_back();
      test_random_polygons();
      req_valid <= 1'b0;

      // Wait for the last vertex, then watch for stray results a little longer.
      while (expected_vertices.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
